// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file abr_checker.sv

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/core/abr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_pkg
// Types, codes and thresholds of the bitrate ladder rung selector.
// ----------------------------------------------------------------------------
package abr_pkg;

  localparam int MAX_RUNGS_DEF   = 6;
  localparam int UPGRADE_DEF     = 8;

  localparam int LOSS_W    = 14;
  localparam int DELAY_W   = 24;
  localparam int TPUT_W    = 36;
  localparam int RATE_W    = 32;
  localparam int RUNG_W    = 3;
  localparam int MOVE_W    = 2;
  localparam int STABLE_W  = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [LOSS_W-1:0]   LOSS_DOWN_BP  = 14'd500;
  localparam logic [LOSS_W-1:0]   LOSS_UP_BP    = 14'd100;
  localparam logic [DELAY_W-1:0]  DELAY_DOWN_US = 24'd200000;
  localparam logic [DELAY_W-1:0]  DELAY_UP_US   = 24'd50000;
  localparam logic [STABLE_W-1:0] STABLE_MAX    = 4'd15;

  localparam logic [MOVE_W-1:0] MOVE_HOLD = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_DOWN = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_UP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RUNG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_0     = 3'd1;

  typedef struct packed {
    logic [LOSS_W-1:0]  loss_basis_points;
    logic [DELAY_W-1:0] queue_delay_us;
    logic [TPUT_W-1:0]  throughput_bps;
  } sample_t;

  typedef struct packed {
    logic              rung_valid;
    logic [RUNG_W-1:0] rung_index;
    logic [RATE_W-1:0] rung_rate;
    logic [MOVE_W-1:0] move;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [RUNG_W-1:0]   next_rung;
    logic [MOVE_W-1:0]   move;
    logic [STABLE_W-1:0] next_stable;
  } decision_t;

endpackage

// File: rtl/core/abr_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_decide
// Step-down / step-up decision for one sample against the active rung.
// ----------------------------------------------------------------------------
module abr_decide
  import abr_pkg::*;
#(
  parameter int UPGRADE_STABLE_SAMPLES = UPGRADE_DEF
) (
  input  sample_t             sample,
  input  logic [RATE_W-1:0]   active_rate,
  input  logic [RUNG_W-1:0]   active_rung,
  input  logic [STABLE_W-1:0] stable_count,
  input  logic [RUNG_W-1:0]   rung_count,
  output decision_t           decision
);

  logic [RATE_W+2:0]  six_rate;
  logic [TPUT_W+2:0]  five_tput_p5;
  logic               tput_low;
  logic               tput_high;
  logic               down;
  logic               up;
  logic               ladder_ok;
  logic [RUNG_W:0]    rung_up;

  // tput < floor(12r/10)  <=>  5*tput + 5 <= 6*r
  assign six_rate     = {1'b0, active_rate, 2'b00} + {2'b00, active_rate, 1'b0};
  assign five_tput_p5 = {1'b0, sample.throughput_bps, 2'b00}
                      + {3'b000, sample.throughput_bps} + (TPUT_W+3)'(5);
  assign tput_low     = (sample.throughput_bps != '0)
                      && (five_tput_p5 <= (TPUT_W+3)'(six_rate));
  assign tput_high    = sample.throughput_bps > TPUT_W'({active_rate, 1'b0});

  assign down = (sample.loss_basis_points >= LOSS_DOWN_BP)
             || (sample.queue_delay_us >= DELAY_DOWN_US) || tput_low;
  assign up   = (stable_count >= STABLE_W'(UPGRADE_STABLE_SAMPLES))
             && (sample.loss_basis_points < LOSS_UP_BP)
             && (sample.queue_delay_us < DELAY_UP_US) && tput_high;

  assign ladder_ok = (rung_count != '0) && (active_rung < rung_count);
  assign rung_up   = {1'b0, active_rung} + (RUNG_W+1)'(1);

  always_comb begin
    decision.valid       = ladder_ok;
    decision.next_rung   = active_rung;
    decision.move        = MOVE_HOLD;
    decision.next_stable = stable_count;
    if (ladder_ok) begin
      if (down && (active_rung != '0)) begin
        decision.next_rung   = active_rung - RUNG_W'(1);
        decision.move        = MOVE_DOWN;
        decision.next_stable = '0;
      end else if (up && (rung_up < {1'b0, rung_count})) begin
        decision.next_rung   = rung_up[RUNG_W-1:0];
        decision.move        = MOVE_UP;
        decision.next_stable = '0;
      end else if (stable_count != STABLE_MAX) begin
        decision.next_stable = stable_count + STABLE_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/abr_ladder_rung_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_ladder_rung_selector_core
// Network-sample driven selector of the active rung of a bitrate ladder.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the result is not stalled and the active
// rate is fresh, and returns one result per sample: the sample goes into an
// input register, and the decision against the active rung is combinational
// and lands in the result register. The rate of the active rung is kept in a
// register read from the rung table through a single port; after every
// configuration write the block reloads it before the next sample is decided.
// Writing the rung count moves to the top rung and clears the stable count.
module abr_ladder_rung_selector_core
  import abr_pkg::*;
#(
  parameter int MAX_RUNGS              = MAX_RUNGS_DEF,
  parameter int UPGRADE_STABLE_SAMPLES = UPGRADE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sample_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_RUNGS > 1) ? $clog2(MAX_RUNGS) : 1;

  logic [RATE_W-1:0]   rung_rate [MAX_RUNGS];
  logic [RUNG_W-1:0]   rung_count;
  logic [RUNG_W-1:0]   active_rung;
  logic [STABLE_W-1:0] stable_count;
  logic [RATE_W-1:0]   active_rate;
  logic                rate_fresh;
  logic                s1_valid;
  sample_t             s1_data;

  logic                cfg_fire;
  logic                advance;
  logic [RUNG_W-1:0]   count_next;
  logic [RUNG_W-1:0]   rate_slot;
  logic [IDX_W-1:0]    rd_addr;
  decision_t           decision;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign advance   = s1_valid && rate_fresh && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign rate_slot = cfg_index - REG_RATE_0;
  assign rd_addr   = advance ? decision.next_rung[IDX_W-1:0] : active_rung[IDX_W-1:0];

  always_comb begin
    count_next = cfg_data[RUNG_W-1:0];
    if (count_next > RUNG_W'(MAX_RUNGS)) begin
      count_next = RUNG_W'(MAX_RUNGS);
    end
  end

  abr_decide #(
    .UPGRADE_STABLE_SAMPLES(UPGRADE_STABLE_SAMPLES)
  ) u_decide (
    .sample       (s1_data),
    .active_rate  (active_rate),
    .active_rung  (active_rung),
    .stable_count (stable_count),
    .rung_count   (rung_count),
    .decision     (decision)
  );

  // rung table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_RUNGS; k++) begin
        rung_rate[k] <= '0;
      end
    end else if (cfg_fire && (cfg_index >= REG_RATE_0) &&
                 (rate_slot < RUNG_W'(MAX_RUNGS))) begin
      rung_rate[rate_slot[IDX_W-1:0]] <= cfg_data;
    end
  end

  // active rate follows the table at the rung that the next decision uses
  always_ff @(posedge clk) begin
    active_rate <= rung_rate[rd_addr];
    if (advance) begin
      out_data.rung_valid <= decision.valid;
      out_data.rung_index <= decision.next_rung;
      out_data.rung_rate  <= decision.valid ? rung_rate[rd_addr] : '0;
      out_data.move       <= decision.move;
    end
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rung_count   <= '0;
      active_rung  <= '0;
      stable_count <= '0;
      rate_fresh   <= 1'b0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rate_fresh <= !cfg_fire;
      if (cfg_fire && (cfg_index == REG_RUNG_COUNT)) begin
        rung_count   <= count_next;
        active_rung  <= (count_next != '0) ? count_next - RUNG_W'(1) : '0;
        stable_count <= '0;
      end else if (advance) begin
        active_rung  <= decision.next_rung;
        stable_count <= decision.next_stable;
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/abr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_checker
// Port-level checks of the rung selector result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abr_checker
  import abr_pkg::*;
#(
  parameter int MAX_RUNGS = MAX_RUNGS_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // stalled result transfer holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // empty ladder result is all zero
  `ASSERT_CLK(a_empty_zero, clk, rst, out_valid && !out_data.rung_valid |-> out_data.rung_index == '0 && out_data.rung_rate == '0 && out_data.move == MOVE_HOLD)

  // only defined move codes
  `ASSERT_NEVER(a_move_code, clk, rst, out_valid && out_data.move != MOVE_HOLD && out_data.move != MOVE_DOWN && out_data.move != MOVE_UP)

  // active rung stays below MAX_RUNGS
  `ASSERT_NEVER(a_rung_range, clk, rst, out_valid && out_data.rung_valid && out_data.rung_index >= RUNG_W'(MAX_RUNGS))

endmodule

bind abr_ladder_rung_selector_core abr_checker #(
  .MAX_RUNGS(MAX_RUNGS)
) u_abr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bitrate ladder rung selector core.
// ----------------------------------------------------------------------------
// Feeds network samples through the valid/ready input channel and collects one
// result per sample. A behavioral copy of the rung decision runs beside the
// block and supplies the expected rung, rate and move for every sample that the
// directed table does not fix. The run starts with a short table of directed
// samples on an empty and on a known ladder, then goes through several random
// ladder setups with samples that lean toward calm links so that the stable
// count fills and upgrades happen. Both sides insert random idle cycles, with stretches of none.
module tb_top;
  import abr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [TPUT_W-1:0]    TPUT_MAX  = '1;

  localparam logic [RATE_W-1:0] R0 = 32'd1000;
  localparam logic [RATE_W-1:0] R1 = 32'd2000;
  localparam logic [RATE_W-1:0] R2 = 32'd50_000_000;
  localparam logic [RATE_W-1:0] R3 = 32'd100_000_000;
  localparam logic [RATE_W-1:0] R4 = 32'd1_000_000_000;
  localparam logic [RATE_W-1:0] R5 = 32'hFFFF_FFFF;

  localparam result_t NO_LADDER = '{1'b0, 3'd0, 32'd0, MOVE_HOLD};

  typedef struct {
    sample_t smp;
    bit      typed;
    result_t want;
  } step_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  sample_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_data  = '0;

  // behavioral ladder state
  int unsigned         ladder_count = 0;
  logic [RATE_W-1:0]   ladder_rate [MAX_RUNGS_DEF];
  logic [RUNG_W-1:0]   cur_rung     = '0;
  logic [STABLE_W-1:0] stable_run   = '0;
  logic [RATE_W-1:0]   plan_rates  [MAX_RUNGS_DEF];

  result_t   pending_rungs [$];
  step_row_t directed_rows [$];
  int        errors     = 0;
  bit        calm_phase = 1'b0;

  abr_ladder_rung_selector_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    foreach (ladder_rate[k]) begin
      ladder_rate[k] = '0;
    end
  end

  function automatic int unsigned draw_wait();
    return calm_phase ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [63:0] cur_rate();
    return (ladder_count == 0) ? 64'd0 : 64'(ladder_rate[cur_rung]);
  endfunction

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    int unsigned n;
    if (idx == REG_RUNG_COUNT) begin
      n = data[2:0];
      if (n > MAX_RUNGS_DEF) n = MAX_RUNGS_DEF;
      ladder_count = n;
      cur_rung     = (n != 0) ? RUNG_W'(n - 1) : '0;
      stable_run   = '0;
    end else if (idx >= REG_RATE_0 && idx < REG_RATE_0 + MAX_RUNGS_DEF) begin
      ladder_rate[idx - REG_RATE_0] = data;
    end
  endtask

  task automatic predict_rung(input sample_t s, output result_t res);
    logic [63:0]       r;
    logic [63:0]       tput;
    bit                down;
    bit                up;
    logic [MOVE_W-1:0] mv;
    res = NO_LADDER;
    if (ladder_count == 0) return;
    r    = ladder_rate[cur_rung];
    tput = s.throughput_bps;
    down = s.loss_basis_points >= LOSS_DOWN_BP || s.queue_delay_us >= DELAY_DOWN_US ||
           (tput != 0 && tput < r * 12 / 10);
    up   = stable_run >= UPGRADE_DEF && s.loss_basis_points < LOSS_UP_BP &&
           s.queue_delay_us < DELAY_UP_US && tput > r * 2;
    mv   = MOVE_HOLD;
    if (down && cur_rung > 0) begin
      cur_rung--;
      stable_run = '0;
      mv = MOVE_DOWN;
    end else if (up && cur_rung + 1 < ladder_count) begin
      cur_rung++;
      stable_run = '0;
      mv = MOVE_UP;
    end else if (stable_run < STABLE_MAX) begin
      stable_run++;
    end
    res.rung_valid = 1'b1;
    res.rung_index = cur_rung;
    res.rung_rate  = ladder_rate[cur_rung];
    res.move       = mv;
  endtask

  function automatic step_row_t mk_row(input logic [LOSS_W-1:0] loss,
                                       input logic [DELAY_W-1:0] delay,
                                       input logic [TPUT_W-1:0] tput,
                                       input bit typed, input result_t want);
    step_row_t row;
    row.smp   = '{loss, delay, tput};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // mostly calm links so the stable count fills, with congestion and noise mixed in
  function automatic sample_t draw_sample();
    sample_t     s;
    logic [63:0] r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] t;
    r  = cur_rate();
    lo = r * 12 / 10;
    hi = r * 2;
    s.loss_basis_points = LOSS_W'($urandom_range(0, 99));
    s.queue_delay_us    = DELAY_W'($urandom_range(0, 49999));
    t = hi + 1 + $urandom_range(0, 4096);
    case ($urandom_range(0, 19))
      14: begin
        t = ($urandom_range(0, 3) == 0) ? 64'd0 : lo + ({$urandom, $urandom} % (hi - lo + 1));
      end
      15: s.loss_basis_points = LOSS_W'($urandom_range(500, 10000));
      16: s.queue_delay_us = DELAY_W'($urandom_range(200000, 24'hFF_FFFF));
      17: t = (lo > 1) ? 1 + ({$urandom, $urandom} % (lo - 1)) : 64'd0;
      18: begin
        s.loss_basis_points = LOSS_W'($urandom);
        s.queue_delay_us    = DELAY_W'($urandom);
        t = {$urandom, $urandom} & 64'(TPUT_MAX);
      end
      19: begin
        case ($urandom_range(0, 5))
          0:       s.loss_basis_points = LOSS_UP_BP - 1;
          1:       s.loss_basis_points = LOSS_UP_BP;
          2:       s.loss_basis_points = LOSS_DOWN_BP - 1;
          3:       s.loss_basis_points = LOSS_DOWN_BP;
          4:       s.loss_basis_points = 14'd10000;
          default: s.loss_basis_points = '1;
        endcase
        case ($urandom_range(0, 4))
          0:       s.queue_delay_us = DELAY_UP_US - 1;
          1:       s.queue_delay_us = DELAY_UP_US;
          2:       s.queue_delay_us = DELAY_DOWN_US - 1;
          3:       s.queue_delay_us = DELAY_DOWN_US;
          default: s.queue_delay_us = '1;
        endcase
        case ($urandom_range(0, 5))
          0:       t = 64'd0;
          1:       t = lo - 1;
          2:       t = lo;
          3:       t = hi;
          4:       t = hi + 1;
          default: t = 64'(TPUT_MAX);
        endcase
      end
      default: ;
    endcase
    if (t > 64'(TPUT_MAX)) t = 64'(TPUT_MAX);
    s.throughput_bps = t[TPUT_W-1:0];
    return s;
  endfunction

  task automatic send_sample(input sample_t s, input bit typed, input result_t want);
    int unsigned gap;
    result_t     pred;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    predict_rung(s, pred);
    pending_rungs.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rungs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
  endtask

  task automatic program_ladder(input logic [RATE_W-1:0] count_word, input bit count_first);
    if (count_first) write_reg(REG_RUNG_COUNT, count_word);
    for (int k = 0; k < MAX_RUNGS_DEF; k++) begin
      write_reg(CFG_IDX_W'(REG_RATE_0 + k), plan_rates[k]);
    end
    write_reg(REG_SPARE, $urandom);
    if (!count_first) write_reg(REG_RUNG_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                             input logic [RATE_W-1:0] got);
    if (got !== want) begin
      if (errors < 100)
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    result_t     want;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_rungs.size() == 0) begin
        if (errors < 100)
          $display("%0t unexpected result: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_rungs.pop_front();
        check_field("rung_valid", 32'(want.rung_valid), 32'(out_data.rung_valid));
        check_field("rung_index", 32'(want.rung_index), 32'(out_data.rung_index));
        check_field("rung_rate", want.rung_rate, out_data.rung_rate);
        check_field("move", 32'(want.move), 32'(out_data.move));
      end
    end
  end

  initial begin : stimulus
    int                n_empty;
    int unsigned       cnt;
    int unsigned       n_items;
    logic [63:0]       step;
    logic [63:0]       acc;
    logic [RATE_W-1:0] count_word;

    // empty ladder after reset, extremes included
    directed_rows.push_back(mk_row('0, '0, '0, 1'b1, NO_LADDER));
    directed_rows.push_back(mk_row('1, '1, TPUT_MAX, 1'b1, NO_LADDER));
    directed_rows.push_back(mk_row(LOSS_DOWN_BP, DELAY_DOWN_US, 36'd1, 1'b1, NO_LADDER));
    directed_rows.push_back(mk_row('0, '0, 36'h8_0000_0001, 1'b1, NO_LADDER));
    n_empty = directed_rows.size();

    // known ladder, starting at the top rung
    directed_rows.push_back(mk_row(LOSS_DOWN_BP, '0, '0, 1'b1, '{1'b1, 3'd4, R4, MOVE_DOWN}));
    directed_rows.push_back(mk_row(LOSS_DOWN_BP - 1, DELAY_DOWN_US - 1, '0, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row('0, DELAY_DOWN_US, '0, 1'b1, '{1'b1, 3'd3, R3, MOVE_DOWN}));
    directed_rows.push_back(mk_row('0, '0, 36'd119_999_999, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row('0, '0, 36'd60_000_000, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row('0, '0, '0, 1'b0, NO_LADDER));
    for (int k = 0; k < 6; k++) begin
      directed_rows.push_back(mk_row('0, '0, 36'd100_000_001, 1'b0, NO_LADDER));
    end
    directed_rows.push_back(mk_row('0, '0, 36'd100_000_000, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row(LOSS_UP_BP - 1, DELAY_UP_US - 1, 36'd100_000_001, 1'b0,
                                   NO_LADDER));
    directed_rows.push_back(mk_row('1, '1, TPUT_MAX, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row(14'd10000, '0, '0, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row(14'd10000, '0, '0, 1'b0, NO_LADDER));
    directed_rows.push_back(mk_row(14'd10000, '0, '0, 1'b1, '{1'b1, 3'd0, R0, MOVE_HOLD}));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (i == n_empty) begin
        drain();
        plan_rates = '{R0, R1, R2, R3, R4, R5};
        program_ladder(32'd6, 1'b0);
      end
      send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0:       cnt = 7;
        1:       cnt = 1;
        2:       cnt = 0;
        3, 4:    cnt = 6;
        5:       cnt = $urandom_range(2, 5);
        6:       cnt = 3;
        default: cnt = 5;
      endcase
      count_word = p[0] ? (($urandom & ~32'd7) | cnt) : RATE_W'(cnt);
      step = (p % 3 == 0) ? 64'd1000 : (p % 3 == 1) ? 64'd1_000_000 : 64'd400_000_000;
      acc  = $urandom_range(0, step);
      for (int k = 0; k < MAX_RUNGS_DEF; k++) begin
        if (p == 3) begin
          plan_rates[k] = (k < 3) ? 32'd0 : 32'hFFFF_FFFF;
        end else begin
          if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
          plan_rates[k] = acc[RATE_W-1:0];
          acc = acc + $urandom_range(1, step);
        end
      end
      program_ladder(count_word, p[0]);
      n_items = (p == 2) ? 20 : 58;
      for (int j = 0; j < n_items; j++) begin
        if (j % 20 == 0) calm_phase = ($urandom_range(0, 3) == 0);
        send_sample(draw_sample(), 1'b0, NO_LADDER);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/abr_pkg.sv
rtl/core/abr_decide.sv
rtl/core/abr_ladder_rung_selector_core.sv
rtl/core/abr_checker.sv
sim/tb_top.sv
